/* rtl/ascs_pkg.sv */
// Package for the four-instruction 8-bit core step block.
// Holds the instruction kinds, opcode masks and status flag packing.
// Used by avr_subset_core_step; depends on nothing else.
`default_nettype none

package ascs_pkg;

    localparam int RF_DEPTH  = 32;
    localparam int RF_ADDR_W = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EXEC  = 1'b1;

    localparam logic [15:0] OPC_NOP   = 16'h0000;
    localparam logic [15:0] MASK_LDI  = 16'hF000;
    localparam logic [15:0] MATCH_LDI = 16'hE000;
    localparam logic [15:0] MASK_MOV  = 16'hFC00;
    localparam logic [15:0] MATCH_MOV = 16'h2C00;
    localparam logic [15:0] MASK_INC  = 16'hFE0F;
    localparam logic [15:0] MATCH_INC = 16'h9403;

    localparam logic [7:0] INC_OVF_VALUE = 8'h7F;

    typedef enum logic [2:0] {
        KIND_WRITE,
        KIND_NOP,
        KIND_LDI,
        KIND_MOV,
        KIND_INC,
        KIND_UNKNOWN
    } instr_kind_t;

    // Flags are kept as {S, V, N, Z}; the status byte has Z at bit 1 up to S at bit 4.
    typedef logic [3:0] flags_t;

    function automatic logic [7:0] flags_to_sreg(flags_t f);
        return {3'b000, f, 1'b0};
    endfunction

endpackage

`default_nettype wire

/* rtl/avr_subset_core_step.sv */
// Top level of the four-instruction 8-bit core step block (NOP, LDI, MOV, INC).
// Program flash lives in two byte banks, registers in a 32-entry memory.
// Depends on ascs_pkg.
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid / s_tready  s_tdata, s_tuser (flash write or execute)
//   m_        out   m_tvalid / m_tready  m_tdata (pc, status, register, unknown)
//
// An item passes the flash fetch, then decode with register read, then
// write-back into the output register; a new item is accepted once the
// previous one has left decode, so items overlap in the pipeline.
// Reset clears pc, flags and the register valid bits; flash needs no clearing.
// A stalled output holds the write-back stage, which in turn holds decode.
`default_nettype none

module avr_subset_core_step #(
    parameter int FLASH_BYTES = 32768
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // flash_address[14:0], flash_data[22:15], reg_index[27:23], zero fill
    input  wire logic [31:0] s_tdata,
    // op[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // program_counter[15:0], status_flags[23:16], reg_value[31:24],
    // unknown_opcode[32], zero fill
    output logic [39:0]      m_tdata
);

    localparam int ADDR_W     = $clog2(FLASH_BYTES);
    localparam int WORD_W     = ADDR_W - 1;
    localparam int WORD_DEPTH = FLASH_BYTES / 2;

    logic                          in_op;
    logic [14:0]                   in_flash_address;
    logic [7:0]                    in_flash_data;
    logic [ascs_pkg::RF_ADDR_W-1:0] in_reg_index;
    logic [ADDR_W-1:0]             wr_addr;
    logic                          s_fire;

    logic [7:0] flash_even_mem [WORD_DEPTH];
    logic [7:0] flash_odd_mem  [WORD_DEPTH];
    logic [7:0] flash_lo_reg;
    logic [7:0] flash_hi_reg;

    logic [7:0] rf_mem [ascs_pkg::RF_DEPTH];
    logic [ascs_pkg::RF_DEPTH-1:0] rf_valid_reg;

    logic                           d_valid_reg;
    logic                           d_op_reg;
    logic [ascs_pkg::RF_ADDR_W-1:0] d_ri_reg;
    logic [15:0]                    d_word;
    ascs_pkg::instr_kind_t          d_kind;
    logic [ascs_pkg::RF_ADDR_W-1:0] d_dest;
    logic [ascs_pkg::RF_ADDR_W-1:0] d_src;
    logic [7:0]                     d_imm;
    logic                           d_move;

    logic [15:0]           pc_reg;
    logic [15:0]           pc_next;
    ascs_pkg::flags_t      flags_reg;
    ascs_pkg::flags_t      flags_next;

    logic                           e_valid_reg;
    ascs_pkg::instr_kind_t          e_kind_reg;
    logic [ascs_pkg::RF_ADDR_W-1:0] e_dest_reg;
    logic [ascs_pkg::RF_ADDR_W-1:0] e_ri_reg;
    logic [7:0]                     e_imm_reg;
    logic [7:0]                     rd_a_data_reg;
    logic [7:0]                     rd_b_data_reg;
    logic                           rd_a_valid_reg;
    logic                           rd_b_valid_reg;
    logic [7:0]                     e_a;
    logic [7:0]                     e_b;
    logic [7:0]                     e_result;
    logic                           e_wr;
    logic [7:0]                     e_report;
    logic                           e_fire;

    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic [39:0] out_data_next;

    assign in_op            = s_tuser[0];
    assign in_flash_address = s_tdata[14:0];
    assign in_flash_data    = s_tdata[22:15];
    assign in_reg_index     = s_tdata[27:23];
    assign wr_addr          = ADDR_W'(in_flash_address);

    assign s_tready = !d_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign d_move   = d_valid_reg && !e_valid_reg;
    assign e_fire   = e_valid_reg && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (s_fire && in_op == ascs_pkg::OP_WRITE)
        begin
            if (wr_addr[0])
            begin
                flash_odd_mem[wr_addr[ADDR_W-1:1]] <= in_flash_data;
            end
            else
            begin
                flash_even_mem[wr_addr[ADDR_W-1:1]] <= in_flash_data;
            end
        end
        if (s_fire && in_op == ascs_pkg::OP_EXEC)
        begin
            flash_lo_reg <= flash_even_mem[pc_reg[WORD_W-1:0]];
            flash_hi_reg <= flash_odd_mem[pc_reg[WORD_W-1:0]];
        end
    end

    assign d_word = {flash_hi_reg, flash_lo_reg};

    always_comb
    begin
        d_kind = ascs_pkg::KIND_UNKNOWN;
        d_dest = d_word[8:4];
        d_src  = d_word[8:4];
        d_imm  = {d_word[11:8], d_word[3:0]};
        priority if (d_op_reg == ascs_pkg::OP_WRITE)
        begin
            d_kind = ascs_pkg::KIND_WRITE;
        end
        else if (d_word == ascs_pkg::OPC_NOP)
        begin
            d_kind = ascs_pkg::KIND_NOP;
        end
        else if ((d_word & ascs_pkg::MASK_LDI) == ascs_pkg::MATCH_LDI)
        begin
            d_kind = ascs_pkg::KIND_LDI;
            d_dest = {1'b1, d_word[7:4]};
        end
        else if ((d_word & ascs_pkg::MASK_MOV) == ascs_pkg::MATCH_MOV)
        begin
            d_kind = ascs_pkg::KIND_MOV;
            d_src  = {d_word[9], d_word[3:0]};
        end
        else if ((d_word & ascs_pkg::MASK_INC) == ascs_pkg::MATCH_INC)
        begin
            d_kind = ascs_pkg::KIND_INC;
        end
        else
        begin
            d_kind = ascs_pkg::KIND_UNKNOWN;
        end
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (d_kind == ascs_pkg::KIND_NOP || d_kind == ascs_pkg::KIND_LDI ||
            d_kind == ascs_pkg::KIND_MOV || d_kind == ascs_pkg::KIND_INC)
        begin
            pc_next = pc_reg + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire && e_wr)
        begin
            rf_mem[e_dest_reg] <= e_result;
        end
        if (d_move)
        begin
            rd_a_data_reg <= rf_mem[d_src];
            rd_b_data_reg <= rf_mem[d_ri_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            d_op_reg <= in_op;
            d_ri_reg <= in_reg_index;
        end
        if (d_move)
        begin
            e_kind_reg <= d_kind;
            e_dest_reg <= d_dest;
            e_ri_reg   <= d_ri_reg;
            e_imm_reg  <= d_imm;
        end
        if (e_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        e_a      = rd_a_valid_reg ? rd_a_data_reg : 8'h00;
        e_b      = rd_b_valid_reg ? rd_b_data_reg : 8'h00;
        e_result = e_a;
        e_wr     = 1'b0;
        flags_next = flags_reg;
        unique case (e_kind_reg)
            ascs_pkg::KIND_LDI:
            begin
                e_result = e_imm_reg;
                e_wr     = 1'b1;
            end
            ascs_pkg::KIND_MOV:
            begin
                e_result = e_a;
                e_wr     = 1'b1;
            end
            ascs_pkg::KIND_INC:
            begin
                e_result = e_a + 8'd1;
                e_wr     = 1'b1;
                flags_next[0] = (e_result == 8'h00);
                flags_next[1] = e_result[7];
                flags_next[2] = (e_a == ascs_pkg::INC_OVF_VALUE);
                flags_next[3] = e_result[7] ^ (e_a == ascs_pkg::INC_OVF_VALUE);
            end
            default:
            begin
                e_result = e_a;
                e_wr     = 1'b0;
            end
        endcase
        e_report = (e_wr && e_dest_reg == e_ri_reg) ? e_result : e_b;
        out_data_next = {7'b0000000, (e_kind_reg == ascs_pkg::KIND_UNKNOWN), e_report,
                         ascs_pkg::flags_to_sreg(flags_next), pc_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= 16'h0000;
            flags_reg      <= '0;
            rf_valid_reg   <= '0;
            rd_a_valid_reg <= 1'b0;
            rd_b_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                d_valid_reg <= 1'b1;
            end
            else if (d_move)
            begin
                d_valid_reg <= 1'b0;
            end
            if (d_move)
            begin
                e_valid_reg    <= 1'b1;
                pc_reg         <= pc_next;
                rd_a_valid_reg <= rf_valid_reg[d_src];
                rd_b_valid_reg <= rf_valid_reg[d_ri_reg];
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end
            if (e_fire)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
                if (e_wr)
                begin
                    rf_valid_reg[e_dest_reg] <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) !d_move |=> $stable(pc_reg))
        else $error("pc changed outside a decode hand-off");

    assert property (@(posedge clk) disable iff (!rst_n)
        d_move |=> (e_valid_reg && !d_valid_reg))
        else $error("decode hand-off left the pipeline in a wrong state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (e_fire && e_wr) |=> rf_valid_reg[$past(e_dest_reg)])
        else $error("register write did not mark its entry valid");
`endif

endmodule

`default_nettype wire

/* bench/core_step_checker.sv */
`timescale 1ns / 100ps
// Checker for the four-instruction core step block: watches both stream channels,
// predicts every result from its own copy of flash, registers, pc and status byte,
// and compares field by field. Depends on ascs_pkg.
module core_step_checker #(
    parameter int FLASH_BYTES = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatches,
    output int          pending,
    output logic [15:0] fetch_pc
);

    localparam int Z_BIT = 1;
    localparam int N_BIT = 2;
    localparam int V_BIT = 3;
    localparam int S_BIT = 4;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  sreg;
        logic [7:0]  reg_value;
        logic        unknown;
    } step_result_t;

    logic [7:0]   flash_image [FLASH_BYTES];
    logic [7:0]   gpr [ascs_pkg::RF_DEPTH];
    logic [15:0]  pc_word = '0;
    logic [7:0]   sreg = '0;
    step_result_t expected_steps [$];
    step_result_t oldest;
    int           fail_total = 0;
    int           waiting = 0;

    assign mismatches = fail_total;
    assign pending    = waiting;
    assign fetch_pc   = pc_word;

    function automatic ascs_pkg::instr_kind_t decode_word(input logic [15:0] w);
        if (w == ascs_pkg::OPC_NOP)
            return ascs_pkg::KIND_NOP;
        if ((w & ascs_pkg::MASK_LDI) == ascs_pkg::MATCH_LDI)
            return ascs_pkg::KIND_LDI;
        if ((w & ascs_pkg::MASK_MOV) == ascs_pkg::MATCH_MOV)
            return ascs_pkg::KIND_MOV;
        if ((w & ascs_pkg::MASK_INC) == ascs_pkg::MATCH_INC)
            return ascs_pkg::KIND_INC;
        return ascs_pkg::KIND_UNKNOWN;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] error in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_total++;
    endtask

    task automatic step_core(input logic op, input logic [14:0] addr, input logic [7:0] data,
                             input logic [4:0] ri);
        logic [15:0]  w;
        logic [4:0]   rd;
        logic [7:0]   old_val;
        logic [7:0]   new_val;
        logic         n;
        logic         v;
        int           lo_addr;
        step_result_t r;
        r.unknown = 1'b0;
        if (op == ascs_pkg::OP_WRITE)
            flash_image[addr] = data;
        else
        begin
            lo_addr = (2 * int'(pc_word)) % FLASH_BYTES;
            w  = {flash_image[(lo_addr + 1) % FLASH_BYTES], flash_image[lo_addr]};
            rd = w[8:4];
            case (decode_word(w))
                ascs_pkg::KIND_NOP:
                    ;
                ascs_pkg::KIND_LDI:
                    gpr[{1'b1, w[7:4]}] = {w[11:8], w[3:0]};
                ascs_pkg::KIND_MOV:
                    gpr[rd] = gpr[{w[9], w[3:0]}];
                ascs_pkg::KIND_INC:
                begin
                    old_val = gpr[rd];
                    new_val = old_val + 8'd1;
                    n = new_val[7];
                    v = (old_val == ascs_pkg::INC_OVF_VALUE);
                    gpr[rd] = new_val;
                    sreg[Z_BIT] = (new_val == 8'd0);
                    sreg[N_BIT] = n;
                    sreg[V_BIT] = v;
                    sreg[S_BIT] = n ^ v;
                end
                default:
                    r.unknown = 1'b1;
            endcase
            if (!r.unknown)
                pc_word = pc_word + 16'd1;
        end
        r.pc        = pc_word;
        r.sreg      = sreg;
        r.reg_value = gpr[ri];
        expected_steps.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ascs_pkg::RF_DEPTH; i++)
                gpr[i] = '0;
            pc_word = '0;
            sreg    = '0;
            expected_steps.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_steps.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata[15:0], 16'h0);
                else
                begin
                    oldest = expected_steps.pop_front();
                    if (m_tdata[15:0] !== oldest.pc)
                        report_mismatch("program_counter", m_tdata[15:0], oldest.pc);
                    if (m_tdata[23:16] !== oldest.sreg)
                        report_mismatch("status_flags", 16'(m_tdata[23:16]),
                                        16'(oldest.sreg));
                    if (m_tdata[31:24] !== oldest.reg_value)
                        report_mismatch("reg_value", 16'(m_tdata[31:24]),
                                        16'(oldest.reg_value));
                    if (m_tdata[32] !== oldest.unknown)
                        report_mismatch("unknown_opcode", 16'(m_tdata[32]),
                                        16'(oldest.unknown));
                end
            end
            if (s_tvalid && s_tready)
                step_core(s_tuser[0], s_tdata[14:0], s_tdata[22:15], s_tdata[27:23]);
        end
        waiting = expected_steps.size();
    end

endmodule

/* bench/avr_subset_core_step_test.sv */
`timescale 1ns / 100ps
// Top of the testbench for the core step block: drives flash writes and executes
// through bursty stimulus, stalls the result channel, and gives the verdict.
// Depends on ascs_pkg, avr_subset_core_step and core_step_checker.
module avr_subset_core_step_test;

    localparam int          FLASH_BYTES  = 32768;
    localparam logic [15:0] ILLEGAL_WORD = 16'hFFFF;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          mismatches;
    int          pending;
    logic [15:0] cur_pc;

    bit          flash_loaded [FLASH_BYTES];
    int          burst_left   = 0;
    int          sent_items   = 0;
    int          ready_left   = 0;
    bit          ready_phase  = 1'b0;
    logic [4:0]  last_ldi_reg = 5'd16;

    avr_subset_core_step #(.FLASH_BYTES(FLASH_BYTES)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    core_step_checker #(.FLASH_BYTES(FLASH_BYTES)) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending),
        .fetch_pc   (cur_pc)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_phase = !ready_phase;
            if (ready_phase)
                ready_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
            else
                ready_left = $urandom_range(1, 6);
        end
        ready_left--;
        m_tready <= ready_phase;
    end

    function automatic logic [15:0] ldi_word(input logic [3:0] d, input logic [7:0] k);
        return ascs_pkg::MATCH_LDI | {4'h0, k[7:4], d, k[3:0]};
    endfunction

    function automatic logic [15:0] mov_word(input logic [4:0] d, input logic [4:0] r);
        return ascs_pkg::MATCH_MOV | {6'b0, r[4], d, r[3:0]};
    endfunction

    function automatic logic [15:0] inc_word(input logic [4:0] d);
        return ascs_pkg::MATCH_INC | {7'b0, d, 4'b0};
    endfunction

    function automatic logic [15:0] random_program_word();
        logic [7:0] k;
        logic [4:0] d;
        case ($urandom_range(0, 3))
            0:
                return ascs_pkg::OPC_NOP;
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       k = ascs_pkg::INC_OVF_VALUE;
                    1:       k = 8'hFF;
                    2:       k = 8'h80;
                    3:       k = 8'h00;
                    default: k = 8'($urandom);
                endcase
                d = 5'($urandom_range(16, 31));
                last_ldi_reg = d;
                return ldi_word(d[3:0], k);
            end
            2:
                return mov_word(5'($urandom), 5'($urandom));
            default:
            begin
                d = $urandom_range(0, 1) ? last_ldi_reg : 5'($urandom);
                return inc_word(d);
            end
        endcase
    endfunction

    function automatic logic [15:0] random_illegal_word();
        logic [3:0] nib;
        do
            nib = 4'($urandom);
        while (nib == 4'h0 || nib == 4'h2 || nib == 4'h9 || nib == 4'hE);
        return {nib, 12'($urandom)};
    endfunction

    task automatic send_item(input logic op, input logic [14:0] addr, input logic [7:0] data,
                             input logic [4:0] ri);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, ri, data, addr};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
        sent_items++;
    endtask

    task automatic write_byte(input int addr, input logic [7:0] data);
        flash_loaded[addr] = 1'b1;
        send_item(ascs_pkg::OP_WRITE, addr[14:0], data, 5'($urandom));
    endtask

    task automatic execute(input logic [4:0] ri);
        send_item(ascs_pkg::OP_EXEC, 15'($urandom), 8'($urandom), ri);
    endtask

    task automatic run_word(input logic [15:0] w, input logic [4:0] ri);
        int base;
        base = (2 * int'(cur_pc)) % FLASH_BYTES;
        if ($urandom_range(0, 1))
        begin
            write_byte(base, w[7:0]);
            write_byte(base + 1, w[15:8]);
        end
        else
        begin
            write_byte(base + 1, w[15:8]);
            write_byte(base, w[7:0]);
        end
        execute(ri);
    endtask

    initial
    begin
        int          goal;
        int          pick;
        int          base;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_word(ascs_pkg::OPC_NOP, 5'd0);
        run_word(ldi_word(4'd0, ascs_pkg::INC_OVF_VALUE), 5'd16);
        run_word(inc_word(5'd16), 5'd16);
        run_word(ldi_word(4'd15, 8'hFF), 5'd31);
        run_word(inc_word(5'd31), 5'd31);
        run_word(mov_word(5'd0, 5'd31), 5'd0);
        run_word(mov_word(5'd31, 5'd16), 5'd31);
        run_word(ILLEGAL_WORD, 5'd31);
        execute(5'd0);
        write_byte(FLASH_BYTES - 1, 8'hFF);
        write_byte(0, 8'h00);

        goal = sent_items + 1200;
        while (sent_items < goal)
        begin
            pick = $urandom_range(0, 99);
            base = (2 * int'(cur_pc)) % FLASH_BYTES;
            if (pick < 55)
                run_word(random_program_word(), 5'($urandom));
            else if (pick < 65)
            begin
                run_word(random_illegal_word(), 5'($urandom));
                if ($urandom_range(0, 1))
                    execute(5'($urandom));
            end
            else if (pick < 80)
                write_byte($urandom_range(0, FLASH_BYTES - 1), 8'($urandom));
            else if (flash_loaded[base] && flash_loaded[base + 1])
                execute(5'($urandom));
            else
                run_word(random_program_word(), 5'($urandom));
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(100_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/ascs_pkg.sv
rtl/avr_subset_core_step.sv
bench/core_step_checker.sv
bench/avr_subset_core_step_test.sv
